>>> hdl/usrb_pkg.sv
// ----------------------------------------------------------------------------
// usrb_pkg
// Types and constants for the ultrasonic ranger with obstacle brake flag.
// ----------------------------------------------------------------------------
package usrb_pkg;

    localparam int unsigned CM_W      = 10;
    localparam int unsigned TRIG_W    = 10;
    localparam int unsigned ELAPSED_W = 20;
    localparam int unsigned TPC_W     = 12;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 20;

    localparam logic [CM_W-1:0]      CM_MAX      = 10'd1023;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 20'hFFFFF;

    localparam logic [TRIG_W-1:0]    TRIGGER_PULSE_RST = 10'd61;
    localparam logic [ELAPSED_W-1:0] TIMEOUT_RST       = 20'd266667;
    localparam logic [TPC_W-1:0]     TICKS_PER_CM_RST  = 12'd348;
    localparam logic [CM_W-1:0]      MAX_VALID_RST     = 10'd650;
    localparam logic [CM_W-1:0]      BRAKE_BELOW_RST   = 10'd20;
    localparam logic [CM_W-1:0]      RELEASE_ABOVE_RST = 10'd25;
    localparam logic [CM_W-1:0]      DISTANCE_RST      = 10'd100;

    typedef enum logic [1:0] {
        PH_IDLE      = 2'd0,
        PH_TRIG      = 2'd1,
        PH_WAIT_RISE = 2'd2,
        PH_COUNT     = 2'd3
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRIGGER_PULSE = 3'd0,
        CFG_TIMEOUT       = 3'd1,
        CFG_TICKS_PER_CM  = 3'd2,
        CFG_MAX_VALID     = 3'd3,
        CFG_BRAKE_BELOW   = 3'd4,
        CFG_RELEASE_ABOVE = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic echo_level;
        logic start_request;
    } req_t;

    typedef struct packed {
        logic            trigger_out;
        logic [CM_W-1:0] distance_cm;
        logic            brake_active;
        logic            new_reading;
        logic            timed_out;
    } rsp_t;

endpackage

>>> hdl/ultrasonic_ranger_with_brake_core.sv
// ----------------------------------------------------------------------------
// ultrasonic_ranger_with_brake_core
// Echo ranger: trigger pulse, echo width to centimetres, brake hysteresis.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid/req_ready   | req_data  (echo, start)
//   rsp     | out       | rsp_valid/rsp_ready   | rsp_data  (one per request)
//   cfg     | in        | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// One request per cycle unless rsp_ready stalls; each result is registered.
// req_ready stays high while the result register is empty or being drained.
// A stalled rsp_ready holds the result and blocks the next request.
// cfg_ready is always high. Reset returns the ranger to idle, distance 100.
// ----------------------------------------------------------------------------
module ultrasonic_ranger_with_brake_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  usrb_pkg::req_t                      req_data,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output usrb_pkg::rsp_t                      rsp_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [usrb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [usrb_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import usrb_pkg::*;

    logic [TRIG_W-1:0]    trigger_pulse_reg;
    logic [ELAPSED_W-1:0] timeout_reg;
    logic [TPC_W-1:0]     ticks_per_cm_reg;
    logic [CM_W-1:0]      max_valid_reg;
    logic [CM_W-1:0]      brake_below_reg;
    logic [CM_W-1:0]      release_above_reg;

    phase_t               phase_reg,    phase_next;
    logic [ELAPSED_W-1:0] elapsed_reg,  elapsed_next;
    logic [TPC_W-1:0]     sub_cm_reg,   sub_cm_next;
    logic [CM_W-1:0]      cm_count_reg, cm_count_next;
    logic [CM_W-1:0]      distance_reg, distance_next;
    logic                 brake_reg,    brake_next;
    logic                 rsp_valid_reg;
    rsp_t                 rsp_data_reg, rsp_data_next;

    logic                 accept;
    logic                 fresh;
    logic                 abandoned;
    logic                 brake_cleared;
    logic [ELAPSED_W-1:0] elapsed_inc;
    logic [TPC_W-1:0]     sub_inc;
    logic                 cm_done;
    logic [TPC_W-1:0]     sub_counted;
    logic [CM_W-1:0]      cm_counted;

    assign cfg_ready = 1'b1;
    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trigger_pulse_reg <= TRIGGER_PULSE_RST;
            timeout_reg       <= TIMEOUT_RST;
            ticks_per_cm_reg  <= TICKS_PER_CM_RST;
            max_valid_reg     <= MAX_VALID_RST;
            brake_below_reg   <= BRAKE_BELOW_RST;
            release_above_reg <= RELEASE_ABOVE_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_TRIGGER_PULSE: trigger_pulse_reg <= cfg_data[TRIG_W-1:0];
                CFG_TIMEOUT:       timeout_reg       <= cfg_data[ELAPSED_W-1:0];
                CFG_TICKS_PER_CM:  ticks_per_cm_reg  <= cfg_data[TPC_W-1:0];
                CFG_MAX_VALID:     max_valid_reg     <= cfg_data[CM_W-1:0];
                CFG_BRAKE_BELOW:   brake_below_reg   <= cfg_data[CM_W-1:0];
                CFG_RELEASE_ABOVE: release_above_reg <= cfg_data[CM_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        elapsed_inc = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg : elapsed_reg + 1'b1;
        sub_inc     = sub_cm_reg + 1'b1;
        cm_done     = (sub_inc >= ticks_per_cm_reg);
        sub_counted = cm_done ? '0 : sub_inc;
        cm_counted  = (cm_done && cm_count_reg < CM_MAX) ? cm_count_reg + 1'b1
                                                         : cm_count_reg;

        phase_next    = phase_reg;
        elapsed_next  = elapsed_reg;
        sub_cm_next   = sub_cm_reg;
        cm_count_next = cm_count_reg;
        distance_next = distance_reg;
        fresh         = 1'b0;
        abandoned     = 1'b0;

        if (phase_reg == PH_IDLE)
        begin
            if (req_data.start_request)
            begin
                phase_next    = PH_TRIG;
                elapsed_next  = '0;
                sub_cm_next   = '0;
                cm_count_next = '0;
            end
        end
        else
        begin
            elapsed_next = elapsed_inc;
            if (elapsed_inc >= timeout_reg)
            begin
                phase_next = PH_IDLE;
                abandoned  = 1'b1;
            end
            else
            begin
                case (phase_reg)
                    PH_TRIG:
                    begin
                        if (elapsed_inc >= {{(ELAPSED_W-TRIG_W){1'b0}}, trigger_pulse_reg})
                        begin
                            phase_next = PH_WAIT_RISE;
                        end
                    end
                    PH_WAIT_RISE:
                    begin
                        if (req_data.echo_level)
                        begin
                            phase_next    = PH_COUNT;
                            sub_cm_next   = sub_counted;
                            cm_count_next = cm_counted;
                        end
                    end
                    default:
                    begin
                        if (req_data.echo_level)
                        begin
                            sub_cm_next   = sub_counted;
                            cm_count_next = cm_counted;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                            if (cm_count_reg < max_valid_reg)
                            begin
                                distance_next = cm_count_reg;
                                fresh         = 1'b1;
                            end
                        end
                    end
                endcase
            end
        end

        brake_cleared = (distance_next > release_above_reg) ? 1'b0 : brake_reg;
        brake_next    = brake_cleared;
        if (distance_next < brake_below_reg && !brake_cleared)
        begin
            brake_next = 1'b1;
        end

        rsp_data_next.trigger_out  = (phase_next == PH_TRIG);
        rsp_data_next.distance_cm  = distance_next;
        rsp_data_next.brake_active = brake_next;
        rsp_data_next.new_reading  = fresh;
        rsp_data_next.timed_out    = abandoned;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            elapsed_reg   <= '0;
            sub_cm_reg    <= '0;
            cm_count_reg  <= '0;
            distance_reg  <= DISTANCE_RST;
            brake_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg    <= phase_next;
                elapsed_reg  <= elapsed_next;
                sub_cm_reg   <= sub_cm_next;
                cm_count_reg <= cm_count_next;
                distance_reg <= distance_next;
                brake_reg    <= brake_next;
            end
            if (req_ready)
            begin
                rsp_valid_reg <= req_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_data_reg <= rsp_data_next;
        end
    end

endmodule

>>> tb/ultrasonic_ranger_with_brake_core_test.sv
// ----------------------------------------------------------------------------
// ultrasonic_ranger_with_brake_core_test
// Self-checking bench for the echo ranger core.
// Runs trigger, echo and timeout sequences through the request channel under
// several register settings and handshake pressure. A scoreboard works out
// every result from its own copy of the ranger state and compares it field
// by field with what the core returns.
// ----------------------------------------------------------------------------
module ultrasonic_ranger_with_brake_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import usrb_pkg::*;

    localparam int PERIOD       = 20;
    localparam int REPORT_LINES = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    class ranger_scoreboard;
        logic [TRIG_W-1:0]    trig_len;
        logic [ELAPSED_W-1:0] timeout_len;
        logic [TPC_W-1:0]     ticks_cm;
        logic [CM_W-1:0]      valid_limit;
        logic [CM_W-1:0]      brake_under;
        logic [CM_W-1:0]      release_over;

        phase_t               ph;
        logic [ELAPSED_W-1:0] elapsed;
        logic [TPC_W-1:0]     sub_cm;
        logic [CM_W-1:0]      cm_count;
        logic [CM_W-1:0]      distance;
        logic                 brake;

        rsp_t                 expected_readings[$];
        int                   readings_checked;
        int                   mismatches;

        function new();
            trig_len         = TRIGGER_PULSE_RST;
            timeout_len      = TIMEOUT_RST;
            ticks_cm         = TICKS_PER_CM_RST;
            valid_limit      = MAX_VALID_RST;
            brake_under      = BRAKE_BELOW_RST;
            release_over     = RELEASE_ABOVE_RST;
            ph               = PH_IDLE;
            elapsed          = '0;
            sub_cm           = '0;
            cm_count         = '0;
            distance         = DISTANCE_RST;
            brake            = 1'b0;
            readings_checked = 0;
            mismatches       = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_TRIGGER_PULSE: trig_len     = value[TRIG_W-1:0];
                CFG_TIMEOUT:       timeout_len  = value[ELAPSED_W-1:0];
                CFG_TICKS_PER_CM:  ticks_cm     = value[TPC_W-1:0];
                CFG_MAX_VALID:     valid_limit  = value[CM_W-1:0];
                CFG_BRAKE_BELOW:   brake_under  = value[CM_W-1:0];
                CFG_RELEASE_ABOVE: release_over = value[CM_W-1:0];
                default:           ;
            endcase
        endfunction

        function void count_echo_tick();
            sub_cm = sub_cm + 1'b1;
            if (sub_cm >= ticks_cm)
            begin
                sub_cm = '0;
                if (cm_count != CM_MAX)
                    cm_count = cm_count + 1'b1;
            end
        endfunction

        function void note_tick(req_t r);
            rsp_t want;
            want = '0;
            if (ph == PH_IDLE)
            begin
                if (r.start_request)
                begin
                    ph       = PH_TRIG;
                    elapsed  = '0;
                    sub_cm   = '0;
                    cm_count = '0;
                end
            end
            else
            begin
                if (elapsed != ELAPSED_MAX)
                    elapsed = elapsed + 1'b1;
                if (elapsed >= timeout_len)
                begin
                    ph             = PH_IDLE;
                    want.timed_out = 1'b1;
                end
                else if (ph == PH_TRIG)
                begin
                    if (elapsed >= trig_len)
                        ph = PH_WAIT_RISE;
                end
                else if (ph == PH_WAIT_RISE)
                begin
                    if (r.echo_level)
                    begin
                        ph = PH_COUNT;
                        count_echo_tick();
                    end
                end
                else if (r.echo_level)
                    count_echo_tick();
                else
                begin
                    ph = PH_IDLE;
                    if (cm_count < valid_limit)
                    begin
                        distance         = cm_count;
                        want.new_reading = 1'b1;
                    end
                end
            end

            if (distance > release_over)
                brake = 1'b0;
            if (distance < brake_under && !brake)
                brake = 1'b1;

            want.trigger_out  = (ph == PH_TRIG);
            want.distance_cm  = distance;
            want.brake_active = brake;
            expected_readings.push_back(want);
        endfunction

        task report(string what);
            mismatches++;
            if (mismatches <= REPORT_LINES)
                $display("reading %0d: %s", readings_checked, what);
        endtask

        task check_reading(rsp_t got);
            rsp_t want;
            readings_checked++;
            if (expected_readings.size() == 0)
            begin
                report("result with no request pending");
                return;
            end
            want = expected_readings.pop_front();
            if (got.trigger_out !== want.trigger_out)
                report($sformatf("trigger_out %b, want %b", got.trigger_out, want.trigger_out));
            if (got.distance_cm !== want.distance_cm)
                report($sformatf("distance_cm %0d, want %0d", got.distance_cm, want.distance_cm));
            if (got.brake_active !== want.brake_active)
                report($sformatf("brake_active %b, want %b", got.brake_active, want.brake_active));
            if (got.new_reading !== want.new_reading)
                report($sformatf("new_reading %b, want %b", got.new_reading, want.new_reading));
            if (got.timed_out !== want.timed_out)
                report($sformatf("timed_out %b, want %b", got.timed_out, want.timed_out));
        endtask
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_ready;
    req_t                  req_data  = '0;
    logic                  rsp_valid;
    logic                  rsp_ready = 1'b0;
    rsp_t                  rsp_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int idle_pct      = 0;
    int stall_pct     = 0;
    int requests_sent = 0;

    ranger_scoreboard sb;

    ultrasonic_ranger_with_brake_core uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(PERIOD / 2) clk = ~clk;

    always @(negedge clk)
        rsp_ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
                sb.check_reading(rsp_data);
            if (req_valid && req_ready)
                sb.note_tick(req_data);
        end
    end

    task automatic send_request(input logic echo, input logic start);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= '{echo_level: echo, start_request: start};
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        requests_sent++;
    endtask

    task automatic run_measurement(input int trig_span, input logic echo_trig,
                                   input int gap_span, input int high_span);
        send_request(echo_trig, 1'b1);
        repeat (trig_span) send_request(echo_trig, $urandom_range(3) == 0);
        repeat (gap_span) send_request(1'b0, $urandom_range(3) == 0);
        repeat (high_span) send_request(1'b1, $urandom_range(3) == 0);
        send_request(1'b0, $urandom_range(3) == 0);
    endtask

    task automatic drain();
        @(negedge clk);
        req_valid <= 1'b0;
        while (sb.expected_readings.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_register(idx, value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_setting(input logic [CFG_DATA_W-1:0] trig,
                                 input logic [CFG_DATA_W-1:0] timeout,
                                 input logic [CFG_DATA_W-1:0] per_cm,
                                 input logic [CFG_DATA_W-1:0] max_valid,
                                 input logic [CFG_DATA_W-1:0] below,
                                 input logic [CFG_DATA_W-1:0] above);
        write_register(CFG_TRIGGER_PULSE, trig);
        write_register(CFG_TIMEOUT, timeout);
        write_register(CFG_TICKS_PER_CM, per_cm);
        write_register(CFG_MAX_VALID, max_valid);
        write_register(CFG_BRAKE_BELOW, below);
        write_register(CFG_RELEASE_ABOVE, above);
    endtask

    task automatic random_bursts(input int quota);
        int goal;
        int trig_cap;
        int trig_span;
        int high_cap;
        goal = requests_sent + quota;
        while (requests_sent < goal)
        begin
            if ($urandom_range(4) != 0)
            begin
                trig_cap = (int'(sb.trig_len) > 30) ? 30 : int'(sb.trig_len);
                if ($urandom_range(3) == 0)
                    trig_span = $urandom_range(trig_cap);
                else
                    trig_span = trig_cap + $urandom_range(1);
                high_cap = (sb.ticks_cm == 0) ? 1 : int'(sb.ticks_cm);
                high_cap = high_cap * (int'(sb.valid_limit) + 2);
                if (high_cap > 60)
                    high_cap = 60;
                run_measurement(trig_span, 1'($urandom_range(1)), $urandom_range(3),
                                $urandom_range(high_cap));
                repeat ($urandom_range(2)) send_request(1'($urandom_range(1)), 1'b0);
            end
            else
                repeat ($urandom_range(1, 6))
                    send_request(1'($urandom_range(1)), 1'($urandom_range(1)));
        end
    endtask

    initial
    begin
        #20ms;
        $display("[ultrasonic_ranger_with_brake_core] ERROR");
        $finish;
    end

    initial
    begin
        sb = new();
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: one short echo after the full trigger pulse
        send_request(1'b1, 1'b0);
        send_request(1'b0, 1'b0);
        send_request(1'b1, 1'b0);
        run_measurement(64, 1'b0, 0, 1);
        drain();

        // echo held through trigger, store, clear brake, discard, timeout on fall
        apply_setting(1, 10, 1, 7, 3, 5);
        run_measurement(1, 1'b1, 0, 2);
        run_measurement(1, 1'b0, 0, 6);
        run_measurement(1, 1'b0, 0, 7);
        run_measurement(1, 1'b0, 0, 8);
        drain();

        idle_pct  = 0;
        stall_pct = 0;
        apply_setting(3, 60, 3, 15, 6, 10);
        random_bursts(120);
        drain();

        idle_pct  = 83;
        stall_pct = 0;
        apply_setting(1, 25, 1, 20, 12, 4);
        random_bursts(110);
        drain();

        // all zero after masking
        idle_pct  = 0;
        stall_pct = 83;
        apply_setting(20'hFFC00, 0, 20'hFF000, 20'hFFC00, 20'hFFC00, 20'h7FC00);
        random_bursts(60);
        drain();

        idle_pct  = 15;
        stall_pct = 15;
        apply_setting(5, 80, 4, 18, 9, 14);
        random_bursts(120);
        drain();

        apply_setting(1023, 35, 4095, 1023, 1023, 1023);
        random_bursts(80);
        drain();

        // saturate the count, then a short reading with overlapping thresholds
        idle_pct  = 0;
        stall_pct = 0;
        apply_setting(0, 20'hFFFFF, 0, 1023, 1023, 0);
        write_register(CFG_SPARE_LO, 20'hFFFFF);
        write_register(CFG_SPARE_HI, 20'h00000);
        run_measurement(1, 1'b0, 0, 1030);
        run_measurement(0, 1'b1, 0, 5);
        drain();

        stall_pct = 83;
        apply_setting(2, 50, 2, 25, 8, 12);
        random_bursts(110);
        drain();

        idle_pct  = 83;
        stall_pct = 0;
        apply_setting(4, 45, 3, 10, 3, 6);
        random_bursts(100);
        drain();

        repeat (5) @(posedge clk);
        if (sb.mismatches == 0)
            $display("[ultrasonic_ranger_with_brake_core] OK");
        else
            $display("[ultrasonic_ranger_with_brake_core] ERROR");
        $finish;
    end
endmodule
